FILE: src/h2r_pkg.sv
// shared types and constants for the hsv to rgb converter
// no dependencies; imported by every module of the block
package h2r_pkg;

    localparam logic [15:0] ONE_Q15  = 16'h8000;
    localparam logic [31:0] HALF_Q15 = 32'h0000_4000;
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [47:0] HALF_Q31 = 48'h0000_4000_0000;
    localparam logic [16:0] ONE_Q16  = 17'h1_0000;

    // hue sector, integer part of hue times six
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    // after sector split and clamping
    typedef struct packed {
        sector_t     sector;
        logic [15:0] frac;
        logic [15:0] sat;
        logic [15:0] val;
        logic [15:0] alpha;
    } h2r_split_t;

    // after the scaled terms are formed
    typedef struct packed {
        sector_t     sector;
        logic [15:0] val;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] t;
        logic [15:0] alpha;
    } h2r_terms_t;

endpackage

FILE: src/h2r_sector.sv
// first stage: hue times six into sector and fraction, clamps s and v
// depends on h2r_pkg
module h2r_sector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic [15:0]         hue,
    input  logic [15:0]         saturation,
    input  logic [15:0]         brightness,
    input  logic [15:0]         alpha_in,
    output logic                dn_valid,
    input  logic                dn_ready,
    output h2r_pkg::h2r_split_t dn_data
);
    import h2r_pkg::*;

    logic       valid_reg;
    logic       load;
    logic [18:0] h6;
    h2r_split_t data_reg;
    h2r_split_t data_next;

    assign load     = !valid_reg || dn_ready;
    assign up_ready = load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // hue * 6 as two shifted adds
    assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb
    begin
        data_next.sector = sector_t'(h6[18:16]);
        data_next.frac   = h6[15:0];
        data_next.sat    = (saturation > ONE_Q15) ? ONE_Q15 : saturation;
        data_next.val    = (brightness > ONE_Q15) ? ONE_Q15 : brightness;
        data_next.alpha  = alpha_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/h2r_scale.sv
// two stages: saturation products, then brightness scaling with rounding
// depends on h2r_pkg
module h2r_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  h2r_pkg::h2r_split_t up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output h2r_pkg::h2r_terms_t dn_data
);
    import h2r_pkg::*;

    // product stage
    logic        a_valid_reg;
    logic        a_load;
    sector_t     a_sector_reg;
    logic [15:0] a_val_reg;
    logic [15:0] a_alpha_reg;
    logic [15:0] a_p_reg;
    logic [31:0] a_sf_reg;
    logic [31:0] a_sfc_reg;

    logic [31:0] p_prod;
    logic [31:0] p_sum;
    logic [16:0] frac_c;
    logic [31:0] sf_prod;
    logic [31:0] sfc_prod;

    // scaling stage
    logic        b_valid_reg;
    logic        b_load;
    h2r_terms_t  b_data_reg;
    h2r_terms_t  b_data_next;
    logic [31:0] q_term;
    logic [31:0] t_term;
    logic [47:0] q_sum;
    logic [47:0] t_sum;

    assign b_load   = !b_valid_reg || dn_ready;
    assign a_load   = !a_valid_reg || b_load;
    assign up_ready = a_load;
    assign dn_valid = b_valid_reg;
    assign dn_data  = b_data_reg;

    assign p_prod   = {16'b0, up_data.val} * {16'b0, ONE_Q15 - up_data.sat};
    assign p_sum    = p_prod + HALF_Q15;
    assign frac_c   = ONE_Q16 - {1'b0, up_data.frac};
    assign sf_prod  = {16'b0, up_data.sat} * {16'b0, up_data.frac};
    // s * (1 - f) never exceeds 2^31
    assign sfc_prod = {16'b0, up_data.sat} * {15'b0, frac_c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && up_valid)
        begin
            a_sector_reg <= up_data.sector;
            a_val_reg    <= up_data.val;
            a_alpha_reg  <= up_data.alpha;
            a_p_reg      <= p_sum[30:15];
            a_sf_reg     <= sf_prod;
            a_sfc_reg    <= sfc_prod;
        end
    end

    assign q_term = ONE_Q31 - a_sf_reg;
    assign t_term = ONE_Q31 - a_sfc_reg;
    assign q_sum  = ({32'b0, a_val_reg} * {16'b0, q_term}) + HALF_Q31;
    assign t_sum  = ({32'b0, a_val_reg} * {16'b0, t_term}) + HALF_Q31;

    always_comb
    begin
        b_data_next.sector = a_sector_reg;
        b_data_next.val    = a_val_reg;
        b_data_next.p      = a_p_reg;
        b_data_next.q      = q_sum[46:31];
        b_data_next.t      = t_sum[46:31];
        b_data_next.alpha  = a_alpha_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_load && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_data_reg.p <= b_data_reg.val) && (b_data_reg.q <= b_data_reg.val)
                        && (b_data_reg.t <= b_data_reg.val))
        else $error("scaled term exceeds brightness");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && $past(b_load) && $past(a_valid_reg) && b_data_reg.sector == SEC_RY
         && $past(a_sf_reg) == 32'd0) |-> (b_data_reg.q == b_data_reg.val))
        else $error("zero saturation product did not give brightness");

endmodule

FILE: src/h2r_select.sv
// output stage: sector picks the rgb permutation of v, p, q and t
// depends on h2r_pkg
module h2r_select (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  h2r_pkg::h2r_terms_t up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output logic [15:0]         red,
    output logic [15:0]         green,
    output logic [15:0]         blue,
    output logic [15:0]         alpha_out
);
    import h2r_pkg::*;

    logic        valid_reg;
    logic        load;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;
    logic [15:0] alpha_reg;
    logic [15:0] red_next;
    logic [15:0] green_next;
    logic [15:0] blue_next;

    assign load      = !valid_reg || dn_ready;
    assign up_ready  = load;
    assign dn_valid  = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

    always_comb
    begin
        case (up_data.sector)
            SEC_RY:
            begin
                red_next = up_data.val; green_next = up_data.t;   blue_next = up_data.p;
            end
            SEC_YG:
            begin
                red_next = up_data.q;   green_next = up_data.val; blue_next = up_data.p;
            end
            SEC_GC:
            begin
                red_next = up_data.p;   green_next = up_data.val; blue_next = up_data.t;
            end
            SEC_CB:
            begin
                red_next = up_data.p;   green_next = up_data.q;   blue_next = up_data.val;
            end
            SEC_BM:
            begin
                red_next = up_data.t;   green_next = up_data.p;   blue_next = up_data.val;
            end
            default:
            begin
                red_next = up_data.val; green_next = up_data.p;   blue_next = up_data.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= up_data.alpha;
        end
    end

endmodule

FILE: src/hsv_to_rgb.sv
// hsv to rgb converter with alpha, q1.15 components and q0.16 hue
// while the output is not stalled, accepts one item per cycle
// four register stages: sector split, products, scaling, permutation
// each stage holds while the one after it is full and stalled
// rst_n clears all valid bits asynchronously; payload registers are not reset
module hsv_to_rgb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] brightness,
    input  logic [15:0] alpha_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic [15:0] alpha_out
);
    import h2r_pkg::*;

    logic       split_valid;
    logic       split_ready;
    h2r_split_t split_data;
    logic       terms_valid;
    logic       terms_ready;
    h2r_terms_t terms_data;

    h2r_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_in   (alpha_in),
        .dn_valid   (split_valid),
        .dn_ready   (split_ready),
        .dn_data    (split_data)
    );

    h2r_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (split_valid),
        .up_ready (split_ready),
        .up_data  (split_data),
        .dn_valid (terms_valid),
        .dn_ready (terms_ready),
        .dn_data  (terms_data)
    );

    h2r_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (terms_valid),
        .up_ready  (terms_ready),
        .up_data   (terms_data),
        .dn_valid  (out_valid),
        .dn_ready  (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_out (alpha_out)
    );

    // a free output side never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= ONE_Q15) && (green <= ONE_Q15) && (blue <= ONE_Q15))
        else $error("color component above one");

    // a stalled result stays put until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(red) && $stable(green)
                                      && $stable(blue) && $stable(alpha_out))
        else $error("result changed while stalled");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the hsv to rgb converter
// depends on h2r_pkg (sector codes, q1.15 constants) and the hsv_to_rgb top
module testbench;

    import h2r_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } rgba_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic [15:0] alpha_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha_out;

    rgba_t pending_pixels[$];
    int    n_errors     = 0;
    int    n_sent       = 0;
    int    n_checked    = 0;
    int    n_clamped    = 0;
    int    n_in_stalls  = 0;
    int    sector_hits[6];
    bit    tx_steady    = 0;
    bit    rx_steady    = 0;
    int    rx_hold      = 0;

    hsv_to_rgb u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("testbench: errors");
        $finish;
    end

    // rgb from hsv with saturation and value clamped to one
    function automatic rgba_t convert_hsv(logic [15:0] h, logic [15:0] s_raw,
                                          logic [15:0] v_raw, logic [15:0] a);
        logic [63:0] s;
        logic [63:0] v;
        logic [18:0] h6;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        rgba_t       px;
        s    = (s_raw > ONE_Q15) ? 64'(ONE_Q15) : 64'(s_raw);
        v    = (v_raw > ONE_Q15) ? 64'(ONE_Q15) : 64'(v_raw);
        h6   = 19'(h) * 19'd6;
        frac = 64'(h6[15:0]);
        p    = (v * (64'(ONE_Q15) - s) + 64'(HALF_Q15)) >> 15;
        q    = (v * (64'(ONE_Q31) - s * frac) + 64'(HALF_Q31)) >> 31;
        t    = (v * (64'(ONE_Q31) - s * (64'(ONE_Q16) - frac)) + 64'(HALF_Q31)) >> 31;
        px.alpha = a;
        case (sector_t'(h6[18:16]))
            SEC_RY:  begin px.red = v[15:0]; px.green = t[15:0]; px.blue = p[15:0]; end
            SEC_YG:  begin px.red = q[15:0]; px.green = v[15:0]; px.blue = p[15:0]; end
            SEC_GC:  begin px.red = p[15:0]; px.green = v[15:0]; px.blue = t[15:0]; end
            SEC_CB:  begin px.red = p[15:0]; px.green = q[15:0]; px.blue = v[15:0]; end
            SEC_BM:  begin px.red = t[15:0]; px.green = p[15:0]; px.blue = v[15:0]; end
            default: begin px.red = v[15:0]; px.green = p[15:0]; px.blue = q[15:0]; end
        endcase
        return px;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // q1.15 value biased toward the ends, with some above one
    function automatic logic [15:0] rand_q15();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 16'd0;
        else if (pick < 20)
            return ONE_Q15;
        else if (pick < 80)
            return 16'($urandom_range(32768));
        else
            return 16'($urandom);
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val,
                                        logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            n_errors++;
        end
    endfunction

    // input side predicts, output side compares with the oldest prediction
    always @(posedge clk)
    begin
        rgba_t exp_px;
        logic [18:0] h6;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("result with no item outstanding: r %0d g %0d b %0d a %0d",
                           red, green, blue, alpha_out);
                    n_errors++;
                end
                else
                begin
                    exp_px = pending_pixels.pop_front();
                    check_field("red", exp_px.red, red);
                    check_field("green", exp_px.green, green);
                    check_field("blue", exp_px.blue, blue);
                    check_field("alpha_out", exp_px.alpha, alpha_out);
                    n_checked++;
                end
            end
            if (in_valid && !in_ready)
                n_in_stalls++;
            if (in_valid && in_ready)
            begin
                pending_pixels.push_back(convert_hsv(hue, saturation, brightness, alpha_in));
                h6 = 19'(hue) * 19'd6;
                sector_hits[h6[18:16]]++;
                if (saturation > ONE_Q15 || brightness > ONE_Q15)
                    n_clamped++;
            end
        end
    end

    // receiver: a counted hold-off when requested, else steady ready or random ready runs
    initial
    begin
        int ready_run;
        bit ready_level;
        ready_run   = 0;
        ready_level = 1'b0;
        out_ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_steady)
                out_ready <= 1'b1;
            else
            begin
                if (ready_run == 0)
                begin
                    ready_level = !ready_level;
                    ready_run   = ready_level ? $urandom_range(1, 12) : idle_gap();
                    if (ready_run == 0)
                    begin
                        ready_level = 1'b1;
                        ready_run   = $urandom_range(1, 12);
                    end
                end
                out_ready <= ready_level;
                ready_run--;
            end
        end
    end

    task automatic send_pixel(input logic [15:0] h, input logic [15:0] s,
                              input logic [15:0] v, input logic [15:0] a);
        int gap;
        gap = tx_steady ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hue        <= h;
        saturation <= s;
        brightness <= v;
        alpha_in   <= a;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] edge_hues[12];
        int i;
        // last and first hue of every sector, plus the wrap point
        edge_hues = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                      16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'hFFFF};
        for (i = 0; i < 12; i++)
            send_pixel(edge_hues[i], ONE_Q15, ONE_Q15, ONE_Q15);
        // zero saturation gives grey
        send_pixel(16'd5000, 16'd0, 16'd20000, 16'd0);
        send_pixel(16'd40000, 16'd0, ONE_Q15, 16'hFFFF);
        // zero brightness gives black
        send_pixel(16'd30000, ONE_Q15, 16'd0, 16'd1234);
        // saturation and brightness above one are clamped
        send_pixel(16'd12345, 16'hFFFF, 16'd30000, 16'd100);
        send_pixel(16'd50000, 16'd32769, 16'hFFFF, 16'd32769);
        send_pixel(16'd60000, 16'd16384, 16'd32769, 16'h7FFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // mid values, alpha with alternating bits and all zeros
        send_pixel(16'h5555, 16'h4000, 16'h4000, 16'hAAAA);
        send_pixel(16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h5555);
        send_pixel(16'd1, 16'd1, 16'd1, 16'd0);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering items back to back
    task automatic test_backpressure();
        int i;
        tx_steady = 1'b1;
        rx_hold   = 150;
        for (i = 0; i < 40; i++)
            send_pixel(16'($urandom), rand_q15(), rand_q15(), 16'($urandom));
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int i;
        for (i = 0; i < n_items; i++)
        begin
            // switch between idle-free stretches and random gaps on both sides
            if (i % 150 == 0)
            begin
                tx_steady = ($urandom_range(3) == 0);
                rx_steady = ($urandom_range(3) == 0);
            end
            if (i % 400 == 399)
                wait_drained();
            send_pixel(16'($urandom), rand_q15(), rand_q15(),
                       ($urandom_range(3) == 0) ? 16'($urandom) : rand_q15());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        hue        = '0;
        saturation = '0;
        brightness = '0;
        alpha_in   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(1590);

        repeat (20) @(posedge clk);
        $display("covered %0d pixels, %0d checked, %0d with clamped inputs, %0d input stalls",
                 n_sent, n_checked, n_clamped, n_in_stalls);
        $display("sector counts %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
                 sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
        if (n_errors == 0 && pending_pixels.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: hsv_to_rgb.f
src/h2r_pkg.sv
src/h2r_sector.sv
src/h2r_scale.sv
src/h2r_select.sv
src/hsv_to_rgb.sv
tb/testbench.sv
